// File: rtl/core/srlp_pkg.sv
// Shared types and constants for the sensor reply line parser.
package srlp_pkg;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } srlp_in_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic        node;
    logic [14:0] temp_centi;
    logic [14:0] humid_centi;
  } srlp_out_t;

  localparam logic [2:0] PH_START   = 3'd0;
  localparam logic [2:0] PH_SKIT    = 3'd1;
  localparam logic [2:0] PH_CAM     = 3'd2;
  localparam logic [2:0] PH_UNKNOWN = 3'd3;
  localparam logic [2:0] PH_TEMP    = 3'd4;
  localparam logic [2:0] PH_HUMID   = 3'd5;
  localparam logic [2:0] PH_IGNORE  = 3'd6;
  localparam logic [2:0] PH_ERR     = 3'd7;

  localparam logic [2:0] EV_ACCEPT  = 3'd0;
  localparam logic [2:0] EV_NODEERR = 3'd1;
  localparam logic [2:0] EV_RANGE   = 3'd2;
  localparam logic [2:0] EV_UNKNOWN = 3'd3;
  localparam logic [2:0] EV_STALE   = 3'd4;

  localparam logic [13:0] MAG_MAX = 14'd16383;
  localparam logic [21:0] AGE_MAX = 22'h3FFFFF;
  localparam logic [21:0] TIMEOUT_RESET = 22'd60000;

  // Result of the parser stage: a line ended with something to report.
  typedef struct packed {
    logic        valid;
    logic [2:0]  event_res;
    logic        node;
    logic [14:0] temp_centi;
    logic [14:0] humid_centi;
  } srlp_line_t;

  function automatic logic [7:0] skit_char(input logic [2:0] i);
    unique case (i)
      3'd0: skit_char = "S";
      3'd1: skit_char = "K";
      3'd2: skit_char = "I";
      3'd3: skit_char = "T";
      3'd4: skit_char = ":";
      default: skit_char = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] cam_char(input logic [2:0] i);
    unique case (i)
      3'd0: cam_char = "C";
      3'd1: cam_char = "A";
      3'd2: cam_char = "M";
      3'd3: cam_char = ":";
      default: cam_char = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] err_char(input logic [3:0] i);
    unique case (i)
      4'd0: err_char = "E";
      4'd1: err_char = "R";
      4'd2: err_char = "R";
      default: err_char = 8'h00;
    endcase
  endfunction

endpackage

// File: rtl/core/srlp_parse.sv
// Byte-level line parser: prefix match, number accumulation, line-end classification.
module srlp_parse import srlp_pkg::*; #(
  parameter int LINE_MAX  = 31,
  parameter int FIELD_MAX = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,       // a byte word is consumed this cycle
  input  logic [7:0] rx_byte,
  output srlp_line_t line_res    // combinational outcome of a newline
);

  localparam int LW = $clog2(LINE_MAX + 1);
  localparam int FW = $clog2(FIELD_MAX + 1);

  logic [2:0]  phase, phase_next;
  logic [LW-1:0] line_length, line_length_next;
  logic [2:0]  prefix_progress, prefix_progress_next;
  logic [FW-1:0] field_length, field_length_next;
  logic [1:0]  err_progress, err_progress_next;
  logic        f_start, f_neg, f_dot, f_stop;
  logic        f_start_next, f_neg_next, f_dot_next, f_stop_next;
  logic [1:0]  frac_digits, frac_digits_next;
  logic [14:0] temp_accum, temp_accum_next;
  logic [14:0] humid_accum, humid_accum_next;

  // number feed shared by both fields
  logic [14:0] feed_in, feed_out;
  logic        nf_start, nf_neg, nf_dot, nf_stop;
  logic [1:0]  nf_frac;
  logic [18:0] m;
  logic [3:0]  d;
  logic        is_digit;

  always_comb begin
    nf_start = f_start;
    nf_neg   = f_neg;
    nf_dot   = f_dot;
    nf_stop  = f_stop;
    nf_frac  = frac_digits;
    feed_out = feed_in;
    is_digit = (rx_byte >= "0") && (rx_byte <= "9");
    d = rx_byte[3:0];
    m = {4'd0, feed_in};
    if (!f_stop) begin
      if (!f_start && (rx_byte == 8'h20 || rx_byte == 8'h09 || rx_byte == 8'h0B ||
                       rx_byte == 8'h0C)) begin
        nf_start = 1'b0;
      end else if (!f_start && (rx_byte == "+" || rx_byte == "-")) begin
        nf_start = 1'b1;
        nf_neg   = (rx_byte == "-");
      end else begin
        nf_start = 1'b1;
        if (is_digit) begin
          if (!f_dot) begin
            m = {4'd0, feed_in} * 19'd10 + {15'd0, d} * 19'd100;
          end else if (frac_digits == 2'd0) begin
            m = {4'd0, feed_in} + {15'd0, d} * 19'd10;
            nf_frac = 2'd1;
          end else if (frac_digits == 2'd1) begin
            m = {4'd0, feed_in} + {15'd0, d};
            nf_frac = 2'd2;
          end
          feed_out = (m > {5'd0, MAG_MAX}) ? {1'b0, MAG_MAX} : m[14:0];
        end else if (rx_byte == "." && !f_dot) begin
          nf_dot = 1'b1;
        end else begin
          nf_stop = 1'b1;
        end
      end
    end
  end

  function automatic logic [14:0] signed_val(input logic neg, input logic [14:0] mag);
    signed_val = neg ? (15'd0 - mag) : mag;
  endfunction

  logic [14:0] humid_val;
  logic signed [14:0] ts, hs;
  logic is_nl, is_cr;

  assign is_nl = (rx_byte == 8'h0A);
  assign is_cr = (rx_byte == 8'h0D);
  assign feed_in = (phase == PH_TEMP) ? temp_accum : humid_accum;

  always_comb begin
    humid_val = signed_val(f_neg, humid_accum);
    ts = temp_accum;
    hs = humid_val;
    line_res = '0;
    if (line_length != '0) begin
      if (phase <= PH_UNKNOWN) begin
        line_res.valid = 1'b1;
        line_res.event_res = EV_UNKNOWN;
      end else if (phase == PH_ERR) begin
        line_res.valid = 1'b1;
        line_res.event_res = EV_NODEERR;
        line_res.node = (prefix_progress == 3'd4);
      end else if (phase == PH_HUMID) begin
        line_res.valid = 1'b1;
        line_res.node = (prefix_progress == 3'd4);
        line_res.temp_centi = temp_accum;
        line_res.humid_centi = humid_val;
        line_res.event_res = (ts < 15'sd500 || ts > 15'sd5000 || hs < 15'sd100 ||
                              hs > 15'sd9900) ? EV_RANGE : EV_ACCEPT;
      end
    end
  end

  always_comb begin
    phase_next = phase;
    line_length_next = line_length;
    prefix_progress_next = prefix_progress;
    field_length_next = field_length;
    err_progress_next = err_progress;
    f_start_next = f_start;
    f_neg_next = f_neg;
    f_dot_next = f_dot;
    f_stop_next = f_stop;
    frac_digits_next = frac_digits;
    temp_accum_next = temp_accum;
    humid_accum_next = humid_accum;
    if (is_nl) begin
      phase_next = PH_START;
      line_length_next = '0;
      prefix_progress_next = '0;
      field_length_next = '0;
      err_progress_next = '0;
      f_start_next = 1'b0;
      f_neg_next = 1'b0;
      f_dot_next = 1'b0;
      f_stop_next = 1'b0;
      frac_digits_next = '0;
      temp_accum_next = '0;
      humid_accum_next = '0;
    end else if (!is_cr && line_length < LW'(LINE_MAX)) begin
      line_length_next = line_length + 1'b1;
      unique case (phase)
        PH_START: begin
          if (rx_byte == "S") begin
            phase_next = PH_SKIT;
            prefix_progress_next = 3'd1;
          end else if (rx_byte == "C") begin
            phase_next = PH_CAM;
            prefix_progress_next = 3'd1;
          end else begin
            phase_next = PH_UNKNOWN;
          end
        end
        PH_SKIT, PH_CAM: begin
          if (phase == PH_SKIT ? rx_byte == skit_char(prefix_progress)
                               : rx_byte == cam_char(prefix_progress)) begin
            prefix_progress_next = prefix_progress + 3'd1;
            if (prefix_progress_next == (phase == PH_SKIT ? 3'd5 : 3'd4))
              phase_next = PH_TEMP;
          end else begin
            phase_next = PH_UNKNOWN;
          end
        end
        PH_TEMP: begin
          if (rx_byte == ",") begin
            if (err_progress == 2'd3 && field_length == FW'(3)) begin
              phase_next = PH_ERR;
            end else begin
              temp_accum_next = signed_val(f_neg, temp_accum);
              phase_next = PH_HUMID;
              f_start_next = 1'b0;
              f_neg_next = 1'b0;
              f_dot_next = 1'b0;
              f_stop_next = 1'b0;
              frac_digits_next = '0;
              field_length_next = '0;
            end
          end else if (rx_byte == 8'h00) begin
            phase_next = PH_IGNORE;
          end else begin
            if (field_length < FW'(3) && FW'(err_progress) == field_length &&
                rx_byte == err_char(4'(field_length)))
              err_progress_next = err_progress + 2'd1;
            temp_accum_next = feed_out;
            f_start_next = nf_start;
            f_neg_next = nf_neg;
            f_dot_next = nf_dot;
            f_stop_next = nf_stop;
            frac_digits_next = nf_frac;
            field_length_next = field_length + 1'b1;
            if (field_length_next >= FW'(FIELD_MAX)) phase_next = PH_IGNORE;
          end
        end
        PH_HUMID: begin
          if (field_length < FW'(FIELD_MAX - 1)) begin
            humid_accum_next = feed_out;
            f_start_next = nf_start;
            f_neg_next = nf_neg;
            f_dot_next = nf_dot;
            f_stop_next = nf_stop;
            frac_digits_next = nf_frac;
            field_length_next = field_length + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      line_length <= '0;
      prefix_progress <= '0;
      field_length <= '0;
      err_progress <= '0;
      f_start <= 1'b0;
      f_neg <= 1'b0;
      f_dot <= 1'b0;
      f_stop <= 1'b0;
      frac_digits <= '0;
      temp_accum <= '0;
      humid_accum <= '0;
    end else if (take) begin
      phase <= phase_next;
      line_length <= line_length_next;
      prefix_progress <= prefix_progress_next;
      field_length <= field_length_next;
      err_progress <= err_progress_next;
      f_start <= f_start_next;
      f_neg <= f_neg_next;
      f_dot <= f_dot_next;
      f_stop <= f_stop_next;
      frac_digits <= frac_digits_next;
      temp_accum <= temp_accum_next;
      humid_accum <= humid_accum_next;
    end
  end

endmodule

// File: rtl/core/srlp_nodes.sv
// Per-node readings, age counters and staleness reporting.
module srlp_nodes import srlp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        line_go,    // newline word consumed
  input  srlp_line_t  line_res,
  input  logic        tick_go,    // tick word consumed
  input  logic [21:0] timeout,
  output logic        stale_hit,
  output logic        stale_node
);

  logic [1:0]  valid, heard, warned;
  logic [14:0] temp_r [2];
  logic [14:0] humid_r [2];
  logic [21:0] age [2];
  logic [21:0] age_inc [2];
  logic [1:0]  over;
  logic        upd;
  logic        unode;

  assign unode = line_res.node;
  assign upd = line_go && line_res.valid &&
               (line_res.event_res == EV_ACCEPT || line_res.event_res == EV_NODEERR);

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      age_inc[i] = (heard[i] && age[i] != AGE_MAX) ? age[i] + 22'd1 : age[i];
      over[i] = heard[i] && (age_inc[i] > timeout);
    end
    stale_hit = 1'b0;
    stale_node = 1'b0;
    if (over[0] && !warned[0]) begin
      stale_hit = 1'b1;
    end else if (over[1] && !warned[1]) begin
      stale_hit = 1'b1;
      stale_node = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_r[0] <= '0;
      temp_r[1] <= '0;
      humid_r[0] <= '0;
      humid_r[1] <= '0;
    end else if (upd) begin
      if (line_res.event_res == EV_ACCEPT) begin
        temp_r[unode] <= line_res.temp_centi;
        humid_r[unode] <= line_res.humid_centi;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      heard <= '0;
      warned <= '0;
      age[0] <= '0;
      age[1] <= '0;
    end else if (tick_go) begin
      for (int i = 0; i < 2; i++) begin
        age[i] <= age_inc[i];
        if (over[i]) valid[i] <= 1'b0;
      end
      if (stale_hit) warned[stale_node] <= 1'b1;
    end else if (upd) begin
      valid[unode] <= (line_res.event_res == EV_ACCEPT);
      heard[unode] <= 1'b1;
      warned[unode] <= 1'b0;
      age[unode] <= '0;
    end
  end

endmodule

// File: rtl/core/sensor_reply_line_parser.sv
// Top level of the sensor reply line parser.
//
//  channel | valid     | ready     | word
//  in      | in_valid  | in_ready  | in_data  (srlp_in_t: operation, rx_byte)
//  out     | out_valid | out_ready | out_data (srlp_out_t: event, node, temp, humid)
//  cfg     | cfg_valid | cfg_ready | cfg_data (stale_timeout_ms, 22 bits)
//
// One word per cycle while in_ready is high: all parsing and node bookkeeping
// happen in the cycle the input word is accepted; a result lands in the output
// register next cycle. in_ready is low only when the output register holds a
// result that is not being taken this cycle. cfg is always ready.
// Synchronous active-high reset clears parser state, node state and sets the
// timeout to 60000 ms.
module sensor_reply_line_parser import srlp_pkg::*; #(
  parameter int LINE_MAX  = 31,
  parameter int FIELD_MAX = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  srlp_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output srlp_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [21:0] cfg_data
);

  logic       take;
  logic       byte_go, tick_go, nl_go;
  srlp_line_t line_res;
  logic       stale_hit, stale_node;
  logic [21:0] timeout;

  // output register frees when empty or drained this cycle
  assign in_ready  = !out_valid || out_ready;
  assign cfg_ready = 1'b1;
  assign take      = in_valid && in_ready;
  assign tick_go   = take && in_data.operation;
  assign byte_go   = take && !in_data.operation;
  assign nl_go     = byte_go && (in_data.rx_byte == 8'h0A);

  srlp_parse #(.LINE_MAX(LINE_MAX), .FIELD_MAX(FIELD_MAX)) u_parse (
    .clk(clk), .rst(rst), .take(byte_go), .rx_byte(in_data.rx_byte),
    .line_res(line_res)
  );

  srlp_nodes u_nodes (
    .clk(clk), .rst(rst), .line_go(nl_go), .line_res(line_res),
    .tick_go(tick_go), .timeout(timeout),
    .stale_hit(stale_hit), .stale_node(stale_node)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= TIMEOUT_RESET;
    end else if (cfg_valid) begin
      timeout <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tick_go && stale_hit) begin
      out_valid <= 1'b1;
      out_data  <= '{EV_STALE, stale_node, 15'd0, 15'd0};
    end else if (nl_go && line_res.valid) begin
      out_valid <= 1'b1;
      out_data  <= '{line_res.event_res, line_res.node, line_res.temp_centi,
                     line_res.humid_centi};
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // a result never arrives while the previous one is still held
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result overwritten");
  a_stale_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.event_res == EV_STALE |-> out_data.temp_centi == 15'd0 &&
    out_data.humid_centi == 15'd0)
    else $error("stale result carries data");
  a_no_result_on_plain_byte: assert property (@(posedge clk) disable iff (rst)
    byte_go && !nl_go && !out_valid |=> !out_valid)
    else $error("result from a non-newline byte");

endmodule

// File: dv/sensor_reply_line_parser_test.sv
// Testbench for the sensor reply line parser: directed lines, then random traffic checked against a predictor.
`timescale 1ns / 100ps

module sensor_reply_line_parser_test;
  import srlp_pkg::*;

  localparam int LINE_LIMIT  = 31;
  localparam int FIELD_LIMIT = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [7:0] NEWLINE = 8'h0A;
  localparam logic [7:0] CR      = 8'h0D;
  localparam logic       OP_BYTE = 1'b0;
  localparam logic       OP_TICK = 1'b1;

  // How a directed row's closing newline is checked.
  typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_GIVEN} row_kind_e;

  typedef struct {
    int        ticks;
    string     text;   // '#' stands for a zero byte
    row_kind_e kind;
    srlp_out_t given;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  srlp_in_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  srlp_out_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [21:0] cfg_data = '0;

  sensor_reply_line_parser DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Line parser and node tracker mirror
  // ---------------------------------------------------------------------------
  logic [2:0]  ln_phase;
  int          ln_length;
  int          ln_prefix;
  int          ln_field;
  int          ln_err;
  logic        nf_start, nf_neg, nf_dot, nf_stop;
  int          ln_frac;
  logic [14:0] ln_temp, ln_humid;
  logic [14:0] nd_temp [2];
  logic [14:0] nd_humid [2];
  logic        nd_valid [2];
  logic        nd_heard [2];
  logic        nd_warned [2];
  logic [21:0] nd_age [2];
  logic [21:0] stale_limit;

  srlp_out_t pending_reports [$];
  int        fails = 0;
  int        words_sent = 0;
  logic      no_idle = 1'b0;
  logic      hold_req = 1'b0;
  logic      use_given = 1'b0;

  function automatic void clear_line();
    ln_phase = PH_START;
    ln_length = 0;
    ln_prefix = 0;
    ln_field = 0;
    ln_err = 0;
    {nf_start, nf_neg, nf_dot, nf_stop} = '0;
    ln_frac = 0;
    ln_temp = '0;
    ln_humid = '0;
  endfunction

  function automatic void reset_mirror();
    clear_line();
    for (int i = 0; i < 2; i++) begin
      nd_temp[i] = '0; nd_humid[i] = '0;
      nd_valid[i] = 0; nd_heard[i] = 0; nd_warned[i] = 0; nd_age[i] = '0;
    end
    stale_limit = TIMEOUT_RESET;
  endfunction

  function automatic void feed_num(inout logic [14:0] acc, input logic [7:0] c);
    int unsigned m;
    int unsigned d;
    m = acc;
    if (nf_stop) return;
    if (!nf_start) begin
      if (c == " " || c == 8'h09 || c == 8'h0B || c == 8'h0C) return;
      if (c == "+" || c == "-") begin
        nf_start = 1;
        if (c == "-") nf_neg = 1;
        return;
      end
      nf_start = 1;
    end
    if (c >= "0" && c <= "9") begin
      d = c - "0";
      if (!nf_dot) m = m * 10 + d * 100;
      else if (ln_frac < 2) begin
        m += (ln_frac == 0) ? d * 10 : d;
        ln_frac++;
      end
      acc = (m > MAG_MAX) ? 15'(MAG_MAX) : 15'(m);
    end else if (c == "." && !nf_dot) begin
      nf_dot = 1;
    end else begin
      nf_stop = 1;
    end
  endfunction

  function automatic logic [14:0] apply_sign(logic [14:0] mag);
    return nf_neg ? 15'(15'd0 - mag) : mag;
  endfunction

  function automatic srlp_out_t report(logic [2:0] ev, logic nd, logic [14:0] t, logic [14:0] h);
    srlp_out_t r;
    r.event_res = ev; r.node = nd; r.temp_centi = t; r.humid_centi = h;
    return r;
  endfunction

  function automatic void mark_heard(int nd);
    nd_heard[nd] = 1; nd_warned[nd] = 0; nd_age[nd] = '0;
  endfunction

  function automatic logic finish_line(output srlp_out_t r);
    int nd;
    logic [14:0] h;
    int ts, hs;
    nd = (ln_prefix == 4) ? 1 : 0;
    if (ln_length == 0) return 0;
    if (ln_phase <= PH_UNKNOWN) begin
      r = report(EV_UNKNOWN, 0, '0, '0);
      return 1;
    end
    if (ln_phase == PH_ERR) begin
      nd_valid[nd] = 0;
      mark_heard(nd);
      r = report(EV_NODEERR, nd[0], '0, '0);
      return 1;
    end
    if (ln_phase == PH_HUMID) begin
      h = apply_sign(ln_humid);
      ts = int'($signed(ln_temp));
      hs = int'($signed(h));
      if (ts < 500 || ts > 5000 || hs < 100 || hs > 9900) begin
        r = report(EV_RANGE, nd[0], ln_temp, h);
      end else begin
        nd_temp[nd] = ln_temp; nd_humid[nd] = h; nd_valid[nd] = 1;
        mark_heard(nd);
        r = report(EV_ACCEPT, nd[0], ln_temp, h);
      end
      return 1;
    end
    return 0;
  endfunction

  function automatic logic [7:0] prefix_char(logic cam, int i);
    string s;
    s = cam ? "CAM:" : "SKIT:";
    return (i < s.len()) ? s[i] : 8'h00;
  endfunction

  function automatic void take_char(logic [7:0] c);
    string err_word;
    int plen;
    err_word = "ERR";
    case (ln_phase)
      PH_START: begin
        if (c == "S") begin ln_phase = PH_SKIT; ln_prefix = 1; end
        else if (c == "C") begin ln_phase = PH_CAM; ln_prefix = 1; end
        else ln_phase = PH_UNKNOWN;
      end
      PH_SKIT, PH_CAM: begin
        plen = (ln_phase == PH_SKIT) ? 5 : 4;
        if (ln_prefix < plen && c == prefix_char(ln_phase == PH_CAM, ln_prefix)) begin
          ln_prefix++;
          if (ln_prefix == plen) ln_phase = PH_TEMP;
        end else begin
          ln_phase = PH_UNKNOWN;
        end
      end
      PH_TEMP: begin
        if (c == ",") begin
          if (ln_err == 3 && ln_field == 3) ln_phase = PH_ERR;
          else begin
            ln_temp = apply_sign(ln_temp);
            ln_phase = PH_HUMID;
            {nf_start, nf_neg, nf_dot, nf_stop} = '0;
            ln_frac = 0;
            ln_field = 0;
          end
        end else if (c == 8'h00) begin
          ln_phase = PH_IGNORE;
        end else begin
          if (ln_field < 3 && ln_err == ln_field && c == err_word[ln_field]) ln_err++;
          feed_num(ln_temp, c);
          ln_field++;
          if (ln_field >= FIELD_LIMIT) ln_phase = PH_IGNORE;
        end
      end
      PH_HUMID: begin
        if (ln_field < FIELD_LIMIT - 1) begin
          feed_num(ln_humid, c);
          ln_field++;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic ms_tick(output srlp_out_t r);
    logic found;
    found = 0;
    for (int i = 0; i < 2; i++)
      if (nd_heard[i] && nd_age[i] < AGE_MAX) nd_age[i]++;
    for (int i = 0; i < 2; i++) begin
      if (nd_heard[i] && nd_age[i] > stale_limit) begin
        nd_valid[i] = 0;
        // only one stale report per tick; the other node waits a tick
        if (!nd_warned[i] && !found) begin
          nd_warned[i] = 1;
          r = report(EV_STALE, i[0], '0, '0);
          found = 1;
        end
      end
    end
    return found;
  endfunction

  function automatic logic predict_word(srlp_in_t w, output srlp_out_t r);
    logic found;
    if (w.operation) return ms_tick(r);
    if (w.rx_byte == NEWLINE) begin
      found = finish_line(r);
      clear_line();
      return found;
    end
    if (w.rx_byte == CR) return 0;
    if (ln_length < LINE_LIMIT) begin
      ln_length++;
      take_char(w.rx_byte);
    end
    return 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Offer one word after a random gap; predict once the handshake completes.
  task automatic put_word(logic op, logic [7:0] b);
    int gap;
    srlp_in_t w;
    srlp_out_t r;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    w.operation = op;
    w.rx_byte = b;
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (predict_word(w, r) && !use_given) pending_reports.push_back(r);
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++)
      put_word(OP_BYTE, (s[i] == "#") ? 8'h00 : s[i]);
  endtask

  task automatic drain();
    // stop offering so the last word is not taken again
    @(negedge clk) in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    // a word with no report may still sit in the block
    repeat (5) @(posedge clk);
  endtask

  task automatic write_timeout(logic [21:0] v);
    @(negedge clk);
    in_valid <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    stale_limit = v & AGE_MAX;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Random line content
  // ---------------------------------------------------------------------------
  function automatic string num_text(int lo, int hi);
    string s;
    int pick;
    s = $sformatf("%0d", $urandom_range(lo, hi));
    if ($urandom_range(0, 2) == 0) begin
      s = {s, "."};
      repeat ($urandom_range(0, 3)) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
    end
    pick = $urandom_range(0, 15);
    if (pick == 0) s = {"-", s};
    else if (pick == 1) s = {"+", s};
    else if (pick == 2) s = {" ", s};
    else if (pick == 3) s = {"\t", s};
    return s;
  endfunction

  function automatic string make_line();
    string s, t, h;
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 9) s = "SKIT:";
    else if (pick < 18) s = "CAM:";
    else if (pick == 18) s = "SKI:";
    else s = "CAMX";
    pick = $urandom_range(0, 19);
    if (pick == 0) t = "ERR";
    else if (pick == 1) t = num_text(0, 999999);
    else if (pick == 2) t = "ERRX";
    else t = num_text(3, 52);
    h = ($urandom_range(0, 9) == 0) ? num_text(0, 99999) : num_text(0, 101);
    s = {s, t};
    if ($urandom_range(0, 19) != 0) s = {s, ",", h};
    if ($urandom_range(0, 9) == 0) s = {s, "\r"};
    if ($urandom_range(0, 24) == 0) s = {s, "#9"};
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker and receiver
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    srlp_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected report: %p", out_data);
        fails++;
      end else begin
        want = pending_reports.pop_front();
        if (out_data.event_res !== want.event_res) begin
          $error("event_res: expected %0d, got %0d", want.event_res, out_data.event_res);
          fails++;
        end
        if (out_data.node !== want.node) begin
          $error("node: expected %0d, got %0d", want.node, out_data.node);
          fails++;
        end
        if (out_data.temp_centi !== want.temp_centi) begin
          $error("temp_centi: expected %0d, got %0d",
                 $signed(want.temp_centi), $signed(out_data.temp_centi));
          fails++;
        end
        if (out_data.humid_centi !== want.humid_centi) begin
          $error("humid_centi: expected %0d, got %0d",
                 $signed(want.humid_centi), $signed(out_data.humid_centi));
          fails++;
        end
      end
    end
  end

  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        // long hold-off: the block fills and drops in_ready
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 10);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  int cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    row_t dir_rows [];
    logic [21:0] timeouts [];
    int budget;
    dir_rows = '{
      '{0, "",                 ROW_NONE,    '0},
      '{0, "SKIT:25.5,40.25",  ROW_PREDICT, '0},
      '{0, "CAM:ERR,x",        ROW_GIVEN,   '{EV_NODEERR, 1'b1, 15'd0, 15'd0}},
      '{0, "SK",               ROW_GIVEN,   '{EV_UNKNOWN, 1'b0, 15'd0, 15'd0}},
      '{1, "FOO:1,2",          ROW_GIVEN,   '{EV_UNKNOWN, 1'b0, 15'd0, 15'd0}},
      '{0, "S#",               ROW_GIVEN,   '{EV_UNKNOWN, 1'b0, 15'd0, 15'd0}},
      '{0, "SKIT:99999,99999", ROW_GIVEN,   '{EV_RANGE, 1'b0, 15'd16383, 15'd16383}},
      '{0, "CAM:-99999,5",     ROW_GIVEN,   '{EV_RANGE, 1'b1, 15'h4001, 15'd500}},
      '{2, "SKIT:5,1",         ROW_GIVEN,   '{EV_ACCEPT, 1'b0, 15'd500, 15'd100}},
      '{0, "CAM:50,99",        ROW_GIVEN,   '{EV_ACCEPT, 1'b1, 15'd5000, 15'd9900}},
      '{0, "SKIT:4.99,50",     ROW_GIVEN,   '{EV_RANGE, 1'b0, 15'd499, 15'd5000}},
      '{0, "SKIT:12.3456,\r 7.891", ROW_PREDICT, '0},
      '{0, "SKIT:123456789,5", ROW_NONE,    '0},
      '{0, "CAM:25",           ROW_NONE,    '0},
      '{0, "SKIT:2#,5",        ROW_NONE,    '0},
      '{0, "SKIT:20,45#9",     ROW_PREDICT, '0},
      '{0, "CAM:-+3,-12.5",    ROW_PREDICT, '0},
      '{0, "SKIT:ERRX,1",      ROW_PREDICT, '0},
      '{0, "SKIT:ERR",         ROW_NONE,    '0},
      '{3, "CAM:20,500000000000000000000000000000000000", ROW_PREDICT, '0}
    };
    // timeout extremes first, then small values that make nodes go stale
    timeouts = '{22'd1, 22'd3600000, 22'd0, 22'h3FFFFF, 22'd5, 22'd17, 22'd40};

    reset_mirror();
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    foreach (dir_rows[i]) begin
      repeat (dir_rows[i].ticks) put_word(OP_TICK, 8'h00);
      put_text(dir_rows[i].text);
      use_given = (dir_rows[i].kind != ROW_PREDICT);
      put_word(OP_BYTE, NEWLINE);
      use_given = 1'b0;
      if (dir_rows[i].kind == ROW_GIVEN) pending_reports.push_back(dir_rows[i].given);
    end
    drain();

    foreach (timeouts[p]) begin
      write_timeout(timeouts[p]);
      no_idle = (p == 3);
      if (p == 1) hold_req = 1'b1;
      budget = words_sent + 120;
      while (words_sent < budget) begin
        repeat ($urandom_range(0, 4)) put_word(OP_TICK, 8'h00);
        if ($urandom_range(0, 9) == 0) begin
          // noise: any byte value, any operation
          repeat ($urandom_range(1, 40))
            put_word($urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)));
        end else begin
          put_text(make_line());
        end
        put_word(OP_BYTE, NEWLINE);
      end
      // sender pauses until every report is back
      drain();
    end

    no_idle = 1'b0;
    @(negedge clk) in_valid <= 1'b0;
    drain();
    repeat (10) @(posedge clk);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/srlp_pkg.sv
rtl/core/srlp_parse.sv
rtl/core/srlp_nodes.sv
rtl/core/sensor_reply_line_parser.sv
dv/sensor_reply_line_parser_test.sv
